FILE: hdl/fale_pkg.sv
// ----------------------------------------------------------------------------
// fale_pkg
// Shared types, sizes and codes of the fully associative lru tag engine.
// ----------------------------------------------------------------------------
package fale_pkg;

  localparam int LINES      = 64;
  localparam int AGE_WIDTH  = 32;
  localparam int IDX_W      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CNT_W      = $clog2(LINES + 1);
  localparam int LIM_W      = 7;
  localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int LINE_OUT_W = 6;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [LIM_W-1:0]    LIMIT_RESET    = LIM_W'(64);
  localparam logic [CFG_AW-3:0]   REG_LINE_LIMIT = '0;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_AGE,
    S_ESCAN,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  device;
    logic [15:0] sector;
    logic [15:0] block_number;
  } in_word_t;

  typedef struct packed {
    logic                  hit;
    logic [LINE_OUT_W-1:0] line;
    logic                  evicted;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  device;
    logic [15:0] sector;
    logic [15:0] block_number;
  } tag_t;

  function automatic logic [LINE_OUT_W-1:0] line_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+LINE_OUT_W-1:0] ext;
    ext = (IDX_W + LINE_OUT_W)'(idx);
    return ext[LINE_OUT_W-1:0];
  endfunction

endpackage

FILE: hdl/fale_ram.sv
// ----------------------------------------------------------------------------
// fale_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/fale_cfg.sv
// ----------------------------------------------------------------------------
// fale_cfg
// Apb register block holding the line limit, clamped to the usable range.
// ----------------------------------------------------------------------------
module fale_cfg
  import fale_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  eff_limit
);

  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [CFG_AW-3:0] reg_idx;
  logic [CMP_W-1:0]  raw_ext;
  logic [CMP_W-1:0]  clamped;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && pready && (reg_idx == REG_LINE_LIMIT)) begin
      limit_nxt = pwdata[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_LINE_LIMIT) begin
      prdata = CFG_DW'(limit_r);
    end
  end

  // zero acts as one, anything above the line count as the line count
  always_comb begin
    raw_ext = CMP_W'(limit_r);
    if (raw_ext == '0) begin
      clamped = CMP_W'(1);
    end else if (raw_ext > CMP_W'(LINES)) begin
      clamped = CMP_W'(LINES);
    end else begin
      clamped = raw_ext;
    end
  end

  assign eff_limit = clamped[CNT_W-1:0];

endmodule

FILE: hdl/fale_seq.sv
// ----------------------------------------------------------------------------
// fale_seq
// Sequencer over the tag and age rams: tag search, aging pass, victim search
// and line write, with the result word register.
// ----------------------------------------------------------------------------
module fale_seq
  import fale_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] eff_limit,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data
);

  state_t                 state_r, state_nxt;
  in_word_t               req_r, req_nxt;
  logic [CNT_W-1:0]       filled_r, filled_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   chk_valid_r, chk_valid_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]       line_r, line_nxt;
  logic                   hit_r, hit_nxt;
  logic                   evict_r, evict_nxt;
  logic [AGE_WIDTH-1:0]   best_age_r, best_age_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   tag_wr_en, tag_rd_en;
  logic [IDX_W-1:0]       tag_wr_addr;
  tag_t                   tag_wr_data;
  logic [$bits(tag_t)-1:0] tag_rd_raw;
  tag_t                   tag_rd;
  logic                   age_wr_en, age_rd_en;
  logic [IDX_W-1:0]       age_wr_addr;
  logic [AGE_WIDTH-1:0]   age_wr_data;
  logic [AGE_WIDTH-1:0]   age_rd;

  logic [CNT_W-1:0]       scan_lim;
  logic                   issue;
  logic                   scan_done;
  logic                   match;
  logic                   is_lookup;
  logic                   has_room;
  logic                   out_free;
  tag_t                   req_tag;

  assign req_tag   = '{device: req_r.device, sector: req_r.sector,
                       block_number: req_r.block_number};
  assign tag_rd    = tag_t'(tag_rd_raw);
  assign scan_lim  = (state_r == S_ESCAN) ? eff_limit : filled_r;
  assign issue     = (rd_idx_r < scan_lim);
  assign scan_done = !chk_valid_r && !issue;
  assign match     = chk_valid_r && (tag_rd == req_tag);
  assign is_lookup = (req_r.kind == KIND_LOOKUP);
  assign has_room  = (filled_r < eff_limit);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fale_ram #(
    .WIDTH ($bits(tag_t)),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_wr_data),
    .rd_en   (tag_rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (tag_rd_raw)
  );

  fale_ram #(
    .WIDTH (AGE_WIDTH),
    .DEPTH (LINES)
  ) u_age_ram (
    .clk     (clk),
    .wr_en   (age_wr_en),
    .wr_addr (age_wr_addr),
    .wr_data (age_wr_data),
    .rd_en   (age_rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (age_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_TSCAN;
        end
      end
      S_TSCAN: begin
        if (match) begin
          state_nxt = is_lookup ? S_AGE : S_WRITE;
        end else if (scan_done) begin
          if (is_lookup) begin
            state_nxt = S_RESP;
          end else if (has_room) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_ESCAN;
          end
        end
      end
      S_AGE: begin
        if (scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_ESCAN: begin
        if (scan_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_nxt       = req_r;
    filled_nxt    = filled_r;
    rd_idx_nxt    = rd_idx_r;
    chk_valid_nxt = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    line_nxt      = line_r;
    hit_nxt       = hit_r;
    evict_nxt     = evict_r;
    best_age_nxt  = best_age_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tag_wr_en     = 1'b0;
    tag_rd_en     = 1'b0;
    tag_wr_addr   = line_r;
    tag_wr_data   = req_tag;
    age_wr_en     = 1'b0;
    age_rd_en     = 1'b0;
    age_wr_addr   = line_r;
    age_wr_data   = '0;

    // common scan stepping, overridden on state changes below
    if (state_r == S_TSCAN || state_r == S_AGE || state_r == S_ESCAN) begin
      chk_valid_nxt = issue;
      chk_idx_nxt   = rd_idx_r[IDX_W-1:0];
      if (issue) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          evict_nxt  = 1'b0;
          line_nxt   = '0;
        end
      end
      S_TSCAN: begin
        tag_rd_en = 1'b1;
        if (match) begin
          hit_nxt       = 1'b1;
          line_nxt      = chk_idx_r;
          rd_idx_nxt    = '0;
          chk_valid_nxt = 1'b0;
        end else if (scan_done) begin
          hit_nxt       = 1'b0;
          line_nxt      = '0;
          rd_idx_nxt    = '0;
          chk_valid_nxt = 1'b0;
          if (!is_lookup) begin
            if (has_room) begin
              line_nxt   = filled_r[IDX_W-1:0];
              filled_nxt = filled_r + 1'b1;
            end else begin
              evict_nxt    = 1'b1;
              best_age_nxt = '0;
            end
          end
        end
      end
      S_AGE: begin
        age_rd_en = 1'b1;
        if (chk_valid_r) begin
          age_wr_en   = 1'b1;
          age_wr_addr = chk_idx_r;
          if (chk_idx_r == line_r) begin
            age_wr_data = '0;
          end else if (age_rd == '1) begin
            age_wr_data = age_rd;
          end else begin
            age_wr_data = age_rd + 1'b1;
          end
        end
      end
      S_ESCAN: begin
        age_rd_en = 1'b1;
        // strictly larger keeps the first line among equal ages
        if (chk_valid_r && (age_rd > best_age_r)) begin
          best_age_nxt = age_rd;
          line_nxt     = chk_idx_r;
        end
      end
      S_WRITE: begin
        tag_wr_en = 1'b1;
        age_wr_en = 1'b1;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{hit: hit_r, line: line_out(line_r), evicted: evict_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      rd_idx_r    <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    chk_idx_r  <= chk_idx_nxt;
    line_r     <= line_nxt;
    hit_r      <= hit_nxt;
    evict_r    <= evict_nxt;
    best_age_r <= best_age_nxt;
    out_data_r <= out_data_nxt;
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(LINES))
    else $error("fill count beyond line count");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.evicted |-> !out_data_r.hit)
    else $error("result reports both hit and eviction");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_TSCAN)
    else $error("accepted word did not start the tag search");

  a_filled_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (filled_r != $past(filled_r)) |->
      filled_r == CNT_W'($past(filled_r) + 1'b1))
    else $error("fill count moved by more than one");

  a_age_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AGE && age_wr_en |-> chk_valid_r && (age_wr_addr == chk_idx_r))
    else $error("aging write outside the checked line");

endmodule

FILE: hdl/fully_assoc_lru_tag_engine.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_engine
// Tag and lru replacement engine of a fully associative block cache.
// ----------------------------------------------------------------------------
// sequence: a lookup runs a tag search over the filled lines, then gives the result;
//   a lookup hit adds an aging pass over the filled lines, an insert that
//   evicts adds a victim search over the first line_limit lines, and an
//   insert ends with one line write.
// flow: one word at a time, each search scanning the tag or age ram line by line
//   through its single read port.
// reset: fill count cleared, line limit 64; ram contents are not cleared.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_engine
  import fale_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data
);

  logic [CNT_W-1:0] eff_limit;

  fale_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_limit (eff_limit)
  );

  fale_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_limit (eff_limit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/fully_assoc_lru_tag_engine_test.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_tag_engine_test
// Self-checking bench for the lru tag engine. Lookups and inserts are driven
// over the valid/stall input channel and every result word is checked against
// a cycle-free model of the tag store, fill count and line ages. The line
// limit is changed between phases, including values outside the legal range
// and values below the current fill count.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_engine_test;
  import fale_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int SETTLE         = 2 * LINES + 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;

  localparam logic [CFG_AW-3:0] REG_SPARE       = 1'b1;
  localparam logic [CFG_AW-1:0] ADDR_LINE_LIMIT = {REG_LINE_LIMIT, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE      = {REG_SPARE, 2'b00};

  localparam tag_t TAG_ONES     = '1;
  localparam tag_t TAG_ZERO     = '0;
  localparam tag_t TAG_NEAR_BLK = {8'hff, 16'hffff, 16'hfffe};
  localparam tag_t TAG_NEAR_DEV = {8'hfe, 16'hffff, 16'hffff};
  localparam tag_t TAG_ALT_A    = {8'haa, 16'h5555, 16'haaaa};
  localparam tag_t TAG_ALT_B    = {8'h55, 16'haaaa, 16'h5555};
  localparam tag_t TAG_MIX_C    = {8'h01, 16'h8000, 16'h0001};
  localparam tag_t TAG_MIX_D    = {8'h80, 16'h0001, 16'h8000};

  class lru_tag_board;
    tag_t                 line_tag [LINES];
    logic [AGE_WIDTH-1:0] line_age [LINES];
    int unsigned          filled;
    logic [LIM_W-1:0]     limit_reg;
    out_word_t            awaited_results [$];
    int unsigned          errors;
    int unsigned          words;
    int unsigned          hits;
    int unsigned          evictions;

    function new();
      filled    = 0;
      limit_reg = LIMIT_RESET;
      errors    = 0;
      words     = 0;
      hits      = 0;
      evictions = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function int unsigned active_limit();
      if (limit_reg < 1) return 1;
      if (limit_reg > LINES) return LINES;
      return limit_reg;
    endfunction

    // works out the result of one accepted word and updates the tag store
    function void note_word(in_word_t w);
      tag_t                 t;
      int                   found;
      int unsigned          lim;
      int unsigned          target;
      logic [AGE_WIDTH-1:0] best_age;
      out_word_t            r;
      t.device       = w.device;
      t.sector       = w.sector;
      t.block_number = w.block_number;
      found = -1;
      for (int i = 0; i < filled && i < LINES; i++) begin
        if (found < 0 && line_tag[i] == t) found = i;
      end
      r.hit     = (found >= 0);
      r.line    = '0;
      r.evicted = 1'b0;
      if (w.kind == KIND_LOOKUP) begin
        if (found >= 0) begin
          for (int i = 0; i < filled && i < LINES; i++) begin
            if (i == found) line_age[i] = '0;
            else if (line_age[i] != '1) line_age[i] = line_age[i] + 1'b1;
          end
          r.line = LINE_OUT_W'(found);
        end
      end else begin
        lim = active_limit();
        if (found >= 0) begin
          target = found;
        end else if (filled < lim) begin
          target = filled;
          filled++;
        end else begin
          // first line below the limit with the strictly largest age
          best_age = '0;
          target   = 0;
          for (int i = 0; i < lim; i++) begin
            if (line_age[i] > best_age) begin
              best_age = line_age[i];
              target   = i;
            end
          end
          r.evicted = 1'b1;
        end
        line_tag[target] = t;
        line_age[target] = '0;
        r.line = LINE_OUT_W'(target);
      end
      words++;
      if (r.hit) hits++;
      if (r.evicted) evictions++;
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_word(out_word_t got);
      out_word_t exp;
      if (awaited_results.size() == 0) begin
        report($sformatf("result word %p with nothing outstanding", got));
      end else begin
        exp = awaited_results.pop_front();
        if (got.hit !== exp.hit)
          report($sformatf("hit %b, expected %b", got.hit, exp.hit));
        if (got.line !== exp.line)
          report($sformatf("line %0d, expected %0d", got.line, exp.line));
        if (got.evicted !== exp.evicted)
          report($sformatf("evicted %b, expected %b", got.evicted, exp.evicted));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;

  lru_tag_board board;
  int           quiet_cycles = 0;
  bit           tx_idle = 1'b0;
  bit           rx_idle = 1'b0;
  bit           long_hold = 1'b0;

  fully_assoc_lru_tag_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_word(out_data);
      if (in_valid && !in_stall) board.note_word(in_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t make_word(input logic kind, input tag_t t);
    in_word_t w;
    w.kind         = kind;
    w.device       = t.device;
    w.sector       = t.sector;
    w.block_number = t.block_number;
    return w;
  endfunction

  function automatic tag_t random_tag();
    tag_t t;
    t.device       = 8'($urandom_range(0, 255));
    t.sector       = 16'($urandom_range(0, 65535));
    t.block_number = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  task automatic send_word(input logic kind, input tag_t t);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= make_word(kind, t);
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // one edge first so the word accepted at this edge is already noted
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    drain(4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[CFG_AW-1:2] == REG_LINE_LIMIT) board.limit_reg = value[LIM_W-1:0];
  endtask

  // pool tags often differ from an earlier one in a single field
  task automatic run_phase(input int count, input int pool_size, input int hold_at,
                           input int pause_at);
    tag_t pool [$];
    tag_t t;
    logic kind;
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(0, 1) == 1) begin
        t = pool[$urandom_range(0, i - 1)];
        case ($urandom_range(0, 2))
          0:       t.device = 8'($urandom_range(0, 255));
          1:       t.sector = 16'($urandom_range(0, 65535));
          default: t.block_number = 16'($urandom_range(0, 65535));
        endcase
      end else begin
        t = random_tag();
      end
      pool.push_back(t);
    end
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) long_hold = 1'b1;
      if (n == pause_at) drain(0);
      if ($urandom_range(0, 9) == 0) t = random_tag();
      else t = pool[$urandom_range(0, pool_size - 1)];
      kind = ($urandom_range(0, 1) == 1) ? KIND_INSERT : KIND_LOOKUP;
      send_word(kind, t);
    end
  endtask

  initial begin : stimulus
    clk      = 1'b0;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_data  = '0;
    board    = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, then fill, hit and reuse at the reset limit
    send_word(KIND_LOOKUP, TAG_ONES);
    send_word(KIND_INSERT, TAG_ONES);
    send_word(KIND_LOOKUP, TAG_NEAR_BLK);
    send_word(KIND_INSERT, TAG_NEAR_BLK);
    send_word(KIND_LOOKUP, TAG_ONES);
    send_word(KIND_INSERT, TAG_ONES);
    send_word(KIND_LOOKUP, TAG_ZERO);

    // limit 0 behaves as 1; line 1 sits above it and still matches
    write_reg(ADDR_LINE_LIMIT, 32'd0);
    send_word(KIND_INSERT, TAG_ZERO);
    send_word(KIND_LOOKUP, TAG_NEAR_BLK);
    send_word(KIND_INSERT, TAG_NEAR_DEV);
    write_reg(ADDR_SPARE, 32'hffff_ffff);
    send_word(KIND_INSERT, TAG_ALT_A);

    // age ordering and tie break on the victim search
    write_reg(ADDR_LINE_LIMIT, 32'd4);
    send_word(KIND_INSERT, TAG_ALT_B);
    send_word(KIND_INSERT, TAG_MIX_C);
    send_word(KIND_LOOKUP, TAG_ALT_B);
    send_word(KIND_LOOKUP, TAG_ALT_A);
    send_word(KIND_INSERT, TAG_MIX_D);
    send_word(KIND_INSERT, TAG_ZERO);

    // limit below the fill count
    write_reg(ADDR_LINE_LIMIT, 32'd2);
    send_word(KIND_LOOKUP, TAG_ALT_B);
    send_word(KIND_INSERT, TAG_ONES);
    send_word(KIND_LOOKUP, TAG_MIX_C);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(ADDR_LINE_LIMIT, 32'hffff_ff7f);
    run_phase(150, 24, 20, -1);

    rx_idle = 1'b0;
    write_reg(ADDR_LINE_LIMIT, 32'd16);
    run_phase(100, 40, -1, 50);

    tx_idle = 1'b0;
    rx_idle = 1'b1;
    write_reg(ADDR_LINE_LIMIT, 32'd64);
    run_phase(130, 90, -1, -1);

    tx_idle = 1'b1;
    write_reg(ADDR_LINE_LIMIT, 32'd1);
    run_phase(40, 8, -1, -1);

    // closing stretch runs without any idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_reg(ADDR_LINE_LIMIT, 32'd5);
    run_phase(130, 12, -1, -1);

    drain(SETTLE);
    $display("covered %0d words with %0d hits and %0d evictions,", board.words,
             board.hits, board.evictions);
    $display("line limits 0, 1, 2, 4, 5, 16, 64 and 127, ignored spare register write");
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fale_pkg.sv
hdl/fale_ram.sv
hdl/fale_cfg.sv
hdl/fale_seq.sv
hdl/fully_assoc_lru_tag_engine.sv
tb/fully_assoc_lru_tag_engine_test.sv
